### rtl/lvb_pkg.sv
// Shared types and constants of the look-at view basis unit.
// No dependencies; every other file of the unit imports this package.
package lvb_pkg;

  // Widest coordinate the datapath carries (upper end of COORD_WIDTH).
  localparam int CoordMaxW = 48;
  // Target minus eye needs one more bit than a coordinate.
  localparam int AimW      = CoordMaxW + 1;
  // Magnitudes of vectors that are being scaled.
  localparam int MagW      = 64;
  // Dot products of a Q2.30 axis with a Q16.16 eye, with headroom.
  localparam int AccW      = 84;

  localparam int QDepth    = 2;
  localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic [1:0] ROW_U = 2'd0;
  localparam logic [1:0] ROW_V = 2'd1;
  localparam logic [1:0] ROW_W = 2'd2;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef struct packed {
    logic               func;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
  } req_t;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] offset;
    logic               degenerate;
    logic               last;
  } res_t;

  // A classified request as it waits in the queue.
  typedef struct packed {
    logic signed [AimW-1:0]      aim_x;
    logic signed [AimW-1:0]      aim_y;
    logic signed [AimW-1:0]      aim_z;
    logic signed [CoordMaxW-1:0] up_x;
    logic signed [CoordMaxW-1:0] up_y;
    logic signed [CoordMaxW-1:0] up_z;
    logic signed [CoordMaxW-1:0] eye_x;
    logic signed [CoordMaxW-1:0] eye_y;
    logic signed [CoordMaxW-1:0] eye_z;
    logic                        aim_zero;
    logic                        up_zero;
  } job_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } rd_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

endpackage

### rtl/lvb_rootdiv.sv
// Shared iterative unit: 64-bit floor square root or 64/32 division,
// one result bit per cycle. Depends on lvb_pkg.
module lvb_rootdiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lvb_pkg::rd_cmd_t cmd_i,
  input  logic [63:0]      num_i,
  input  logic [31:0]      den_i,
  output lvb_pkg::rd_stat_t stat_o,
  output logic [31:0]      res_o
);
  import lvb_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        is_div_q;
  logic [4:0]  cnt_q;
  logic [63:0] x_q, x_d;
  logic [63:0] r_q, r_d;
  logic [63:0] bit_q;
  logic [31:0] den_q;

  logic [63:0] sq_sum;
  logic [32:0] dv_top;
  logic [32:0] dv_diff;

  always_comb begin
    sq_sum  = r_q + bit_q;
    dv_top  = x_q[63:31];
    dv_diff = dv_top - {1'b0, den_q};
    x_d     = x_q;
    r_d     = r_q;
    if (is_div_q) begin
      if (dv_top >= {1'b0, den_q}) begin
        x_d = {dv_diff[31:0], x_q[30:0], 1'b1};
      end else begin
        x_d = {x_q[62:0], 1'b0};
      end
    end else begin
      if (x_q >= sq_sum) begin
        x_d = x_q - sq_sum;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
    end
    busy_d = busy_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
    end else if (busy_q && (cnt_q == 5'd31)) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      is_div_q <= cmd_i.is_div;
      x_q      <= num_i;
      r_q      <= '0;
      bit_q    <= 64'h4000_0000_0000_0000;
      den_q    <= den_i;
    end else if (busy_q) begin
      x_q   <= x_d;
      r_q   <= r_d;
      bit_q <= bit_q >> 2;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = is_div_q ? x_q[31:0] : r_q[31:0];

endmodule

### rtl/lvb_front.sv
// Front end: takes requests, extracts coordinates, forms the aim vector
// and flags zero aim or zero up. Depends on lvb_pkg.
module lvb_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lvb_pkg::req_t req_i,
  output logic          busy_o,
  input  logic          full_i,
  output logic          push_o,
  output lvb_pkg::job_t job_o
);
  import lvb_pkg::*;

  localparam int  TakeW   = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam bit  SignExt = (COORD_WIDTH <= 32);

  logic valid_q;
  job_t job_q, job_d;
  logic accept;

  // Fields wider than the coordinate keep their low bits; a coordinate
  // wider than the field sees the field as a non-negative value.
  function automatic logic signed [CoordMaxW-1:0] coord(input logic [31:0] f);
    logic [TakeW-1:0] t;
    logic             s;
    t = f[TakeW-1:0];
    s = SignExt ? t[TakeW-1] : 1'b0;
    return {{(CoordMaxW - TakeW){s}}, t};
  endfunction

  logic signed [CoordMaxW-1:0] ax, ay, az, ex, ey, ez;

  always_comb begin
    ax = coord(req_i.aim_x);
    ay = coord(req_i.aim_y);
    az = coord(req_i.aim_z);
    ex = coord(req_i.eye_x);
    ey = coord(req_i.eye_y);
    ez = coord(req_i.eye_z);
    job_d.eye_x = ex;
    job_d.eye_y = ey;
    job_d.eye_z = ez;
    job_d.up_x  = coord(req_i.up_x);
    job_d.up_y  = coord(req_i.up_y);
    job_d.up_z  = coord(req_i.up_z);
    if (req_i.func) begin
      job_d.aim_x = AimW'(ax) - AimW'(ex);
      job_d.aim_y = AimW'(ay) - AimW'(ey);
      job_d.aim_z = AimW'(az) - AimW'(ez);
    end else begin
      job_d.aim_x = AimW'(ax);
      job_d.aim_y = AimW'(ay);
      job_d.aim_z = AimW'(az);
    end
    job_d.aim_zero = (job_d.aim_x == '0) && (job_d.aim_y == '0) && (job_d.aim_z == '0);
    job_d.up_zero  = (job_d.up_x == '0) && (job_d.up_y == '0) && (job_d.up_z == '0);
  end

  assign busy_o = valid_q && full_i;
  assign push_o = valid_q && !full_i;
  assign accept = start_i && !busy_o;
  assign job_o  = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

endmodule

### rtl/lvb_queue.sv
// Short queue of classified requests between front and back end.
// Depends on lvb_pkg.
module lvb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lvb_pkg::job_t data_i,
  input  logic          pop_i,
  output lvb_pkg::job_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import lvb_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  function automatic logic [QPtrW-1:0] nxt(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= nxt(wr_q);
      end
      if (do_pop) begin
        rd_q <= nxt(rd_q);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/lvb_back.sv
// Back end: sequencer that scales, normalizes and crosses the vectors,
// forms the offsets and emits three rows per request.
// Depends on lvb_pkg and lvb_rootdiv.
module lvb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  lvb_pkg::job_t job_i,
  output logic          pop_o,
  output logic          res_valid_o,
  output lvb_pkg::res_t res_o
);
  import lvb_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SCALE     = 4'd1;
  localparam logic [3:0] ST_MAC       = 4'd2;
  localparam logic [3:0] ST_DRAIN     = 4'd3;
  localparam logic [3:0] ST_USE       = 4'd4;
  localparam logic [3:0] ST_ROOT_GO   = 4'd5;
  localparam logic [3:0] ST_ROOT_WAIT = 4'd6;
  localparam logic [3:0] ST_DIV_GO    = 4'd7;
  localparam logic [3:0] ST_DIV_WAIT  = 4'd8;
  localparam logic [3:0] ST_DEGEN     = 4'd9;

  localparam logic [1:0] TK_SQ  = 2'd0;
  localparam logic [1:0] TK_XC  = 2'd1;
  localparam logic [1:0] TK_XV  = 2'd2;
  localparam logic [1:0] TK_OFS = 2'd3;

  localparam logic [1:0] PH_W  = 2'd0;
  localparam logic [1:0] PH_UP = 2'd1;
  localparam logic [1:0] PH_U  = 2'd2;

  localparam logic signed [AccW-1:0] OfsRnd = {{(AccW - 30){1'b0}}, 1'b1, 29'b0};
  localparam logic signed [AccW-1:0] SatMax = {{(AccW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [AccW-1:0] SatMin = {{(AccW - 31){1'b1}}, 31'b0};

  typedef struct packed {
    logic valid;
    logic first;
    logic sub;
    logic sh16;
  } mac_ctl_t;

  logic [3:0] state_q, state_d;
  logic [1:0] task_q, task_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] idx_q, idx_d;
  logic [1:0] comp_q, comp_d;
  mac_ctl_t   mac_q, mac_d;
  logic       res_valid_q, res_valid_d;

  job_t                  job_q, job_d;
  logic [MagW-1:0]       m_q [3];
  logic [MagW-1:0]       m_d [3];
  logic                  neg_q [3];
  logic                  neg_d [3];
  logic signed [31:0]    w_q [3];
  logic signed [31:0]    w_d [3];
  logic signed [31:0]    u_q [3];
  logic signed [31:0]    u_d [3];
  logic signed [31:0]    v_q [3];
  logic signed [31:0]    v_d [3];
  logic signed [31:0]    ups_q [3];
  logic signed [31:0]    ups_d [3];
  logic [31:0]           len_q, len_d;
  logic signed [65:0]    prod_q, prod_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  res_t                  res_q, res_d;

  logic signed [32:0]    mul_a, mul_b;
  logic signed [AccW-1:0] prod_ext, term;
  logic signed [AccW-1:0] acc_mag, ofs_t, ofs_n;
  logic signed [31:0]    ofs_val;
  logic [MagW-1:0]       rnd, ov;
  logic signed [31:0]    v_val;
  logic [31:0]           q_clamp;
  logic [1:0]            cp, cq, ci;
  logic [2:0]            n_last;
  logic signed [31:0]    row_ax [3];
  logic signed [CoordMaxW-1:0] up_v [3];
  logic signed [CoordMaxW-1:0] eye_v [3];
  logic signed [AimW-1:0]      aim_v [3];

  rd_cmd_t     rd_cmd;
  rd_stat_t    rd_stat;
  logic [63:0] rd_num;
  logic [31:0] rd_res;

  lvb_rootdiv u_rootdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (rd_cmd),
    .num_i  (rd_num),
    .den_i  (len_q),
    .stat_o (rd_stat),
    .res_o  (rd_res)
  );

  function automatic logic [MagW-1:0] mag_of(input logic signed [AimW-1:0] x);
    logic signed [AimW-1:0] a;
    a = x[AimW-1] ? -x : x;
    return MagW'($unsigned(a));
  endfunction

  function automatic logic [1:0] row_code(input logic [1:0] c);
    logic [1:0] r;
    case (c)
      2'd0:    r = ROW_U;
      2'd1:    r = ROW_V;
      default: r = ROW_W;
    endcase
    return r;
  endfunction

  assign up_v[0]  = job_q.up_x;
  assign up_v[1]  = job_q.up_y;
  assign up_v[2]  = job_q.up_z;
  assign eye_v[0] = job_q.eye_x;
  assign eye_v[1] = job_q.eye_y;
  assign eye_v[2] = job_q.eye_z;
  assign aim_v[0] = job_i.aim_x;
  assign aim_v[1] = job_i.aim_y;
  assign aim_v[2] = job_i.aim_z;

  assign pop_o         = (state_q == ST_IDLE) && !empty_i;
  assign rd_cmd.start  = (state_q == ST_ROOT_GO) || (state_q == ST_DIV_GO);
  assign rd_cmd.is_div = (state_q == ST_DIV_GO);
  assign rd_num        = (state_q == ST_ROOT_GO) ? acc_q[63:0]
                       : (64'(m_q[comp_q][31:0]) << 30) + 64'(len_q >> 1);

  // Operand selection and arithmetic helpers.
  always_comb begin
    case (comp_q)
      2'd0:    begin cp = 2'd1; cq = 2'd2; end
      2'd1:    begin cp = 2'd2; cq = 2'd0; end
      default: begin cp = 2'd0; cq = 2'd1; end
    endcase
    ci = idx_q[2:1];
    for (int i = 0; i < 3; i++) begin
      if (comp_q == ROW_U) begin
        row_ax[i] = u_q[i];
      end else if (comp_q == ROW_V) begin
        row_ax[i] = v_q[i];
      end else begin
        row_ax[i] = w_q[i];
      end
    end
    mac_d      = '0;
    mul_a      = '0;
    mul_b      = '0;
    n_last     = 3'd1;
    case (task_q)
      TK_SQ: begin
        n_last = 3'd2;
        mul_a  = {1'b0, m_q[idx_q[1:0]][31:0]};
        mul_b  = {1'b0, m_q[idx_q[1:0]][31:0]};
      end
      TK_XC: begin
        mul_a     = 33'(idx_q[0] ? w_q[cq] : w_q[cp]);
        mul_b     = 33'(idx_q[0] ? ups_q[cp] : ups_q[cq]);
        mac_d.sub = idx_q[0];
      end
      TK_XV: begin
        mul_a     = 33'(idx_q[0] ? w_q[cq] : w_q[cp]);
        mul_b     = 33'(idx_q[0] ? u_q[cp] : u_q[cq]);
        mac_d.sub = idx_q[0];
      end
      default: begin
        n_last     = 3'd5;
        mul_a      = 33'(row_ax[ci]);
        mac_d.sh16 = !idx_q[0];
        if (idx_q[0]) begin
          mul_b = {17'b0, eye_v[ci][15:0]};
        end else begin
          mul_b = 33'(signed'(eye_v[ci][CoordMaxW-1:16]));
        end
      end
    endcase
    mac_d.valid = (state_q == ST_MAC);
    mac_d.first = (idx_q == '0);
    prod_d      = mul_a * mul_b;

    prod_ext = AccW'(prod_q);
    if (mac_q.sh16) begin
      prod_ext = prod_ext <<< 16;
    end
    term = mac_q.sub ? -prod_ext : prod_ext;
    if (!mac_q.valid) begin
      acc_d = acc_q;
    end else if (mac_q.first) begin
      acc_d = term;
    end else begin
      acc_d = acc_q + term;
    end

    acc_mag = acc_q[AccW-1] ? -acc_q : acc_q;
    rnd     = (acc_mag[63:0] + 64'h2000_0000) >> 30;
    if (rnd > 64'h4000_0000) begin
      v_val = ONE_Q30;
    end else begin
      v_val = rnd[31:0];
    end
    if (acc_q[AccW-1]) begin
      v_val = -v_val;
    end

    // Offset: negate round(dot / 2^30), ties toward plus infinity.
    ofs_t = acc_q + OfsRnd;
    ofs_n = -(ofs_t >>> 30);
    if (ofs_n > SatMax) begin
      ofs_val = 32'sh7FFF_FFFF;
    end else if (ofs_n < SatMin) begin
      ofs_val = 32'sh8000_0000;
    end else begin
      ofs_val = ofs_n[31:0];
    end

    q_clamp = (rd_res > 32'h4000_0000) ? 32'h4000_0000 : rd_res;
    ov      = m_q[0] | m_q[1] | m_q[2];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    task_d      = task_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    comp_d      = comp_q;
    res_valid_d = 1'b0;
    job_d       = job_q;
    m_d         = m_q;
    neg_d       = neg_q;
    w_d         = w_q;
    u_d         = u_q;
    v_d         = v_q;
    ups_d       = ups_q;
    len_d       = len_q;
    res_d       = res_q;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          job_d  = job_i;
          comp_d = '0;
          if (job_i.aim_zero || job_i.up_zero) begin
            state_d = ST_DEGEN;
          end else begin
            for (int i = 0; i < 3; i++) begin
              m_d[i]   = mag_of(aim_v[i]);
              neg_d[i] = aim_v[i][AimW-1];
            end
            phase_d = PH_W;
            state_d = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (ov == '0) begin
          comp_d  = '0;
          state_d = ST_DEGEN;
        end else if (|ov[MagW-1:39]) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 8;
        end else if (|ov[MagW-1:31]) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 1;
        end else if (ov[MagW-1:22] == '0) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 8;
        end else if (ov[MagW-1:30] == '0) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 1;
        end else begin
          idx_d   = '0;
          comp_d  = '0;
          state_d = ST_MAC;
          if (phase_q == PH_UP) begin
            for (int i = 0; i < 3; i++) begin
              ups_d[i] = neg_q[i] ? -signed'(m_q[i][31:0]) : signed'(m_q[i][31:0]);
            end
            task_d = TK_XC;
          end else begin
            task_d = TK_SQ;
          end
        end
      end
      ST_MAC: begin
        if (idx_q == n_last) begin
          idx_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_USE;
      end
      ST_USE: begin
        case (task_q)
          TK_SQ: begin
            state_d = ST_ROOT_GO;
          end
          TK_XC: begin
            m_d[comp_q]   = acc_mag[63:0];
            neg_d[comp_q] = acc_q[AccW-1];
            if (comp_q == 2'd2) begin
              comp_d  = '0;
              phase_d = PH_U;
              state_d = ST_SCALE;
            end else begin
              comp_d  = comp_q + 2'd1;
              state_d = ST_MAC;
            end
          end
          TK_XV: begin
            v_d[comp_q] = v_val;
            state_d     = ST_MAC;
            if (comp_q == 2'd2) begin
              comp_d = '0;
              task_d = TK_OFS;
            end else begin
              comp_d = comp_q + 2'd1;
            end
          end
          default: begin
            res_valid_d      = 1'b1;
            res_d.row        = row_code(comp_q);
            res_d.axis_x     = row_ax[0];
            res_d.axis_y     = row_ax[1];
            res_d.axis_z     = row_ax[2];
            res_d.offset     = ofs_val;
            res_d.degenerate = 1'b0;
            res_d.last       = (comp_q == 2'd2);
            if (comp_q == 2'd2) begin
              state_d = ST_IDLE;
            end else begin
              comp_d  = comp_q + 2'd1;
              state_d = ST_MAC;
            end
          end
        endcase
      end
      ST_ROOT_GO: begin
        state_d = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (rd_stat.done) begin
          len_d   = rd_res;
          comp_d  = '0;
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (rd_stat.done) begin
          if (phase_q == PH_W) begin
            w_d[comp_q] = neg_q[comp_q] ? -signed'(q_clamp) : signed'(q_clamp);
          end else begin
            u_d[comp_q] = neg_q[comp_q] ? -signed'(q_clamp) : signed'(q_clamp);
          end
          if (comp_q != 2'd2) begin
            comp_d  = comp_q + 2'd1;
            state_d = ST_DIV_GO;
          end else begin
            comp_d = '0;
            if (phase_q == PH_W) begin
              for (int i = 0; i < 3; i++) begin
                m_d[i]   = mag_of(AimW'(up_v[i]));
                neg_d[i] = up_v[i][CoordMaxW-1];
              end
              phase_d = PH_UP;
              state_d = ST_SCALE;
            end else begin
              idx_d   = '0;
              task_d  = TK_XV;
              state_d = ST_MAC;
            end
          end
        end
      end
      ST_DEGEN: begin
        res_valid_d      = 1'b1;
        res_d.row        = row_code(comp_q);
        res_d.axis_x     = '0;
        res_d.axis_y     = '0;
        res_d.axis_z     = '0;
        res_d.offset     = '0;
        res_d.degenerate = 1'b1;
        res_d.last       = (comp_q == 2'd2);
        if (comp_q == 2'd2) begin
          state_d = ST_IDLE;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      task_q      <= TK_SQ;
      phase_q     <= PH_W;
      idx_q       <= '0;
      comp_q      <= '0;
      mac_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      task_q      <= task_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      comp_q      <= comp_d;
      mac_q       <= mac_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    m_q    <= m_d;
    neg_q  <= neg_d;
    w_q    <= w_d;
    u_q    <= u_d;
    v_q    <= v_d;
    ups_q  <= ups_d;
    len_q  <= len_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/look_at_view_basis_unit.sv
// Channel   Direction  Signals                     Handshake
// request   in         start_i, req_i, busy_o      taken when start_i && !busy_o
// result    out        res_valid_o, res_o          one cycle per row, no stall
//
// Each request yields three rows (u, v, w), emitted at the end of its run.
// The shared root/divide unit does eight runs (two roots, six divides) per
// request. A zero aim, a zero up or an aim parallel to up finishes early and
// gives three degenerate rows. Up to three requests are held (front register
// plus a two-entry queue) while one is in work; busy_o rises only when all
// are full. Reset clears control.
module look_at_view_basis_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lvb_pkg::req_t req_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output lvb_pkg::res_t res_o
);
  import lvb_pkg::*;

  job_t fr_job, q_job;
  logic fr_push, q_full, q_empty, q_pop;

  lvb_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .full_i  (q_full),
    .push_o  (fr_push),
    .job_o   (fr_job)
  );

  lvb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  (fr_job),
    .pop_i   (q_pop),
    .data_o  (q_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lvb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .job_i       (q_job),
    .pop_o       (q_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

`ifndef ASSERT_OFF
  a_busy_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> q_full)
    else $error("busy raised while the queue has room");

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.degenerate) |->
      (res_o.axis_x == 0 && res_o.axis_y == 0 && res_o.axis_z == 0 && res_o.offset == 0))
    else $error("degenerate row carries nonzero data");

  a_axis_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |->
      (res_o.axis_x <= ONE_Q30 && res_o.axis_x >= -ONE_Q30 &&
       res_o.axis_y <= ONE_Q30 && res_o.axis_y >= -ONE_Q30 &&
       res_o.axis_z <= ONE_Q30 && res_o.axis_z >= -ONE_Q30))
    else $error("axis component exceeds unit magnitude");

  a_last_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !res_valid_o || (res_o.row == ROW_U))
    else $error("row after the last row is not a right axis row");
`endif

endmodule
